FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the field tokenizer.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked on every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: rtl/core/ift_pkg.sv
// Types and constants of the input field tokenizer.
// Used by the stage modules and the top level.
package ift_pkg;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;

  typedef enum logic [2:0] {
    MODE_LEAD   = 3'd0,
    MODE_QUOTED = 3'd1,
    MODE_AFTERQ = 3'd2,
    MODE_PLAIN  = 3'd3,
    MODE_REST   = 3'd4
  } ift_mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } ift_item_t;

  typedef struct packed {
    logic [7:0] value_char;
    logic [7:0] space_run;
    logic       char_valid;
    logic       field_done;
    logic       extra_input;
  } ift_result_t;

  typedef struct packed {
    ift_mode_e  mode;
    logic [7:0] held;
    logic       extra;
  } ift_status_t;

endpackage

FILE: rtl/core/ift_if.sv
// Valid/ready channel interfaces for character words in and result words out.
// No dependencies beyond the language.
interface ift_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface ift_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_char;
  logic [7:0] space_run;
  logic       char_valid;
  logic       field_done;
  logic       extra_input;

  modport source (output valid, output value_char, output space_run, output char_valid,
                  output field_done, output extra_input, input ready);
  modport sink   (input valid, input value_char, input space_run, input char_valid,
                  input field_done, input extra_input, output ready);
endinterface

FILE: rtl/core/ift_in_stage.sv
// Input register of the tokenizer: captures one character word per cycle while the word it holds can advance.
// Depends on ift_pkg and ift_in_if.
module ift_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  ift_in_if.sink            in_i,
  input  logic              advance_i,
  output logic              valid_o,
  output ift_pkg::ift_item_t item_o
);

  logic               valid_q, valid_d;
  ift_pkg::ift_item_t item_q, item_d;
  logic               take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d          = 1'b1;
      item_d.char_code = in_i.char_code;
      item_d.line_end  = in_i.line_end;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/core/ift_parse.sv
// Field parser: mode register, held-space counter and extra-text flag,
// with the per-character decision logic. Depends on ift_pkg.
module ift_parse #(
  parameter int MAX_LINE = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  ift_pkg::ift_item_t   item_i,
  output logic                 res_valid_o,
  output ift_pkg::ift_result_t res_o,
  output ift_pkg::ift_status_t status_o
);

  localparam int         CapInt   = (MAX_LINE > 255) ? 255 : MAX_LINE;
  localparam logic [7:0] SpaceCap = 8'(CapInt);

  ift_pkg::ift_mode_e mode_q, mode_d;
  logic [7:0]         held_q, held_d;
  logic               extra_q, extra_d;

  always_comb begin
    mode_d      = mode_q;
    held_d      = held_q;
    extra_d     = extra_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (item_i.line_end) begin
      // close the line; trailing held spaces drop here
      res_valid_o       = 1'b1;
      res_o.field_done  = 1'b1;
      res_o.extra_input = extra_q;
      mode_d            = ift_pkg::MODE_LEAD;
      held_d            = '0;
      extra_d           = 1'b0;
    end else begin
      unique case (mode_q)
        ift_pkg::MODE_LEAD: begin
          if (item_i.char_code == ift_pkg::ChQuote) begin
            mode_d = ift_pkg::MODE_QUOTED;
          end else if (item_i.char_code == ift_pkg::ChComma) begin
            mode_d = ift_pkg::MODE_REST;
          end else if (item_i.char_code != ift_pkg::ChSpace) begin
            mode_d           = ift_pkg::MODE_PLAIN;
            res_valid_o      = 1'b1;
            res_o.value_char = item_i.char_code;
            res_o.char_valid = 1'b1;
          end
        end
        ift_pkg::MODE_QUOTED: begin
          if (item_i.char_code == ift_pkg::ChQuote) begin
            mode_d = ift_pkg::MODE_AFTERQ;
          end else begin
            res_valid_o      = 1'b1;
            res_o.value_char = item_i.char_code;
            res_o.char_valid = 1'b1;
          end
        end
        ift_pkg::MODE_AFTERQ: begin
          if (item_i.char_code == ift_pkg::ChComma) begin
            mode_d = ift_pkg::MODE_REST;
          end
        end
        ift_pkg::MODE_PLAIN: begin
          if (item_i.char_code == ift_pkg::ChComma) begin
            held_d = '0;
            mode_d = ift_pkg::MODE_REST;
          end else if (item_i.char_code == ift_pkg::ChSpace) begin
            // saturate; further spaces of the run are lost
            if (held_q < SpaceCap) begin
              held_d = held_q + 8'd1;
            end
          end else begin
            // release held spaces with this character
            res_valid_o      = 1'b1;
            res_o.value_char = item_i.char_code;
            res_o.space_run  = held_q;
            res_o.char_valid = 1'b1;
            held_d           = '0;
          end
        end
        ift_pkg::MODE_REST: begin
          if (item_i.char_code != ift_pkg::ChSpace) begin
            extra_d = 1'b1;
          end
        end
        default: begin
          mode_d  = ift_pkg::MODE_LEAD;
          held_d  = '0;
          extra_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ift_pkg::MODE_LEAD;
      held_q  <= '0;
      extra_q <= 1'b0;
    end else if (advance_i) begin
      mode_q  <= mode_d;
      held_q  <= held_d;
      extra_q <= extra_d;
    end
  end

  assign status_o.mode  = mode_q;
  assign status_o.held  = held_q;
  assign status_o.extra = extra_q;

endmodule

FILE: rtl/core/ift_out_stage.sv
// Result register of the tokenizer: holds one result word until taken.
// Depends on ift_pkg and ift_out_if.
module ift_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  ift_pkg::ift_result_t res_i,
  output logic                 free_o,
  ift_out_if.source            out_o
);

  logic                 valid_q, valid_d;
  ift_pkg::ift_result_t res_q, res_d;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid       = valid_q;
  assign out_o.value_char  = res_q.value_char;
  assign out_o.space_run   = res_q.space_run;
  assign out_o.char_valid  = res_q.char_valid;
  assign out_o.field_done  = res_q.field_done;
  assign out_o.extra_input = res_q.extra_input;

endmodule

FILE: rtl/core/input_field_tokenizer_top.sv
// Channel    | Dir | Word contents
// -----------+-----+------------------------------------------------------
// in_i       | in  | char_code, line_end
// out_o      | out | value_char, space_run, char_valid, field_done, extra_input
//
// One character word per cycle while out_o is not stalled; a result word passes
// the input register and then the result register before it is presented on out_o.
// Words that produce no result still pass through the input register.
// Reset returns the parser to leading-space mode with no held spaces.
// A stalled output holds the result register, and the input register backs up
// behind it; ready drops only when both registers are full and out_o is stalled.
// Depends on ift_pkg, ift_if, ift_in_stage, ift_parse, ift_out_stage.
`include "assert_macros.svh"

module input_field_tokenizer_top #(
  parameter int MAX_LINE = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ift_in_if.sink    in_i,
  ift_out_if.source out_o
);

  localparam int         CapInt   = (MAX_LINE > 255) ? 255 : MAX_LINE;
  localparam logic [7:0] SpaceCap = 8'(CapInt);

  logic                 stage_valid;
  ift_pkg::ift_item_t   stage_item;
  logic                 res_valid;
  ift_pkg::ift_result_t res;
  ift_pkg::ift_status_t status;
  logic                 out_free;
  logic                 advance;
  logic                 end_taken;
  logic                 parse_clear;
  logic                 done_clean;
  logic                 run_held;
  logic                 in_plain;

  // advance the held word only when the result register can take its result
  assign advance = stage_valid && out_free;

  ift_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  ift_parse #(
    .MAX_LINE (MAX_LINE)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (stage_item),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status)
  );

  ift_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance && res_valid),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

  assign end_taken   = advance && stage_item.line_end;
  assign parse_clear = (status.mode == ift_pkg::MODE_LEAD) && (status.held == 8'd0) &&
                       !status.extra;
  assign done_clean  = !out_o.char_valid && (out_o.space_run == 8'd0) &&
                       (out_o.value_char == 8'd0);
  assign run_held    = res_valid && (res.space_run != 8'd0);
  assign in_plain    = (status.mode == ift_pkg::MODE_PLAIN);

  `ASSERT_PROP(a_line_end_resets, clk_i, rst_ni, end_taken |=> parse_clear)
  `ASSERT_NEVER(a_held_over_cap, clk_i, rst_ni, status.held > SpaceCap)
  `ASSERT_PROP(a_done_word_clean, clk_i, rst_ni, (out_o.valid && out_o.field_done) |-> done_clean)
  `ASSERT_PROP(a_space_only_plain, clk_i, rst_ni, run_held |-> in_plain)

endmodule
